### design/mlp_forward_evaluator_defines.svh
// Assertion macros used by the evaluator top level.
// Expects clk and rst in the scope of each use.
`ifndef MLP_FORWARD_EVALUATOR_DEFINES_SVH
`define MLP_FORWARD_EVALUATOR_DEFINES_SVH

// Same-cycle implication
`define MLP_FE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define MLP_FE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/mlp_fe_pkg.sv
// Shared types, constants and the logistic table for the MLP evaluator.
// No dependencies.
package mlp_fe_pkg;

  localparam int VAL_BITS  = 16;
  localparam int ACC_BITS  = 40;
  localparam int FRAC_BITS = 12;
  localparam int NCELL     = 32;
  localparam int WT_DEPTH  = 96;
  localparam int TAB_DEPTH = 256;
  localparam int DRAIN_LEN = NCELL + 8;
  localparam int FLUSH_LEN = 8;

  localparam logic signed [40:0] ACC_MAX = 41'sd549755813887;

  // Configuration register indexes
  localparam logic [2:0] REG_LAYER_COUNT = 3'd0;
  localparam logic [2:0] REG_INPUT_WIDTH = 3'd1;
  localparam logic [2:0] REG_HIDDEN_ONE  = 3'd2;
  localparam logic [2:0] REG_HIDDEN_TWO  = 3'd3;
  localparam logic [2:0] REG_GAIN_A      = 3'd4;
  localparam logic [2:0] REG_NEG_RECIP   = 3'd5;
  localparam logic [2:0] REG_OFFSET_C    = 3'd6;

  // Item function codes
  localparam logic FUNC_WEIGHT = 1'b0;
  localparam logic FUNC_INPUT  = 1'b1;

  localparam logic [1:0] GAP_NONE = 2'd3;

  typedef struct packed {
    logic              func;
    logic [1:0]        weight_gap;
    logic [4:0]        from_node;
    logic [4:0]        to_node;
    logic [4:0]        input_position;
    logic signed [15:0] value;
    logic              last;
  } item_t;

  typedef struct packed {
    logic signed [15:0] score;
    logic               saturated;
  } result_t;

  // Value moving down the cell chain
  typedef struct packed {
    logic               valid;
    logic               first;
    logic [4:0]         k;
    logic signed [15:0] value;
  } tok_t;

  // Node sum travelling through the activation pipeline
  typedef struct packed {
    logic       valid;
    logic       clip;
    logic [4:0] idx;
  } act_meta_t;

  typedef struct packed {
    logic signed [15:0] gain;
    logic signed [15:0] recip;
    logic signed [15:0] offset;
  } act_cfg_t;

  typedef logic [12:0] logi_tab_t [TAB_DEPTH];

  // Shift-subtract quotient, used only while the table is built
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      quo = quo << 1;
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Logistic table, built at elaboration with Q32.32 arithmetic; entries are Q1.12
  function automatic logi_tab_t build_logi();
    logi_tab_t  tab;
    logic [63:0] step;
    logic [63:0] r;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] q;
    step = udiv64(64'd8 << 32, 64'(TAB_DEPTH));
    r    = 64'd1 << 32;
    term = 64'd1 << 32;
    e    = 64'd1 << 32;
    for (int n = 1; n <= 12; n++) begin
      term = udiv64((term * step) >> 32, 64'(n));
      if (n[0]) r = r - term;
      else r = r + term;
    end
    for (int i = 0; i < TAB_DEPTH; i++) begin
      d      = (64'd1 << 32) + e;
      q      = udiv64((64'd4096 << 32) + (d >> 1), d);
      tab[i] = q[12:0];
      e      = (e * r + (64'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

  localparam logi_tab_t LOGI_TAB = build_logi();

endpackage

### design/mlp_fe_cell.sv
// One MAC cell of the chain: owns the weight column of one destination node.
// Depends on mlp_fe_pkg.
module mlp_fe_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               wt_we,
  input  logic [6:0]         wt_addr,
  input  logic signed [15:0] wt_data,
  input  logic [1:0]         gap,
  input  mlp_fe_pkg::tok_t   tok_in,
  output mlp_fe_pkg::tok_t   tok_out,
  input  logic               shift,
  input  logic signed [39:0] acc_in,
  input  logic               clip_in,
  output logic signed [39:0] acc,
  output logic               clip
);

  logic signed [15:0] mem [mlp_fe_pkg::WT_DEPTH];
  logic signed [15:0] wt;
  mlp_fe_pkg::tok_t   tok;
  logic signed [31:0] prod;
  logic               prod_valid;
  logic               prod_first;
  logic signed [40:0] base;
  logic signed [40:0] sum;
  logic signed [39:0] acc_next;
  logic               hit;

  // Weight column store
  always_ff @(posedge clk) begin
    if (wt_we) mem[wt_addr] <= wt_data;
  end

  always_ff @(posedge clk) begin
    wt <= mem[{gap, tok_in.k}];
  end

  // Token hop to the neighbor
  always_ff @(posedge clk) begin
    if (rst) tok <= '0;
    else tok <= tok_in;
  end
  assign tok_out = tok;

  // Product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      prod_first <= 1'b0;
    end else begin
      prod_valid <= tok.valid;
      prod_first <= tok.first;
    end
    prod <= 32'(wt) * 32'(tok.value);
  end

  // Saturating accumulate
  always_comb begin
    base = prod_first ? 41'sd0 : 41'(acc);
    sum  = base + 41'(prod);
    hit  = 1'b0;
    acc_next = sum[39:0];
    if (sum > mlp_fe_pkg::ACC_MAX) begin
      acc_next = mlp_fe_pkg::ACC_MAX[39:0];
      hit = 1'b1;
    end else if (sum < -mlp_fe_pkg::ACC_MAX) begin
      acc_next = 40'(-mlp_fe_pkg::ACC_MAX);
      hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      clip <= 1'b0;
    end else if (shift) begin
      acc  <= acc_in;
      clip <= clip_in;
    end else if (prod_valid) begin
      acc  <= acc_next;
      clip <= prod_first ? hit : (clip | hit);
    end
  end

endmodule

### design/mlp_fe_act.sv
// Five-stage activation pipeline: round and saturate, scale, logistic, gain, round/offset/saturate.
// Depends on mlp_fe_pkg.
module mlp_fe_act (
  input  logic                    clk,
  input  logic                    rst,
  input  mlp_fe_pkg::act_cfg_t    cfg,
  input  mlp_fe_pkg::act_meta_t   meta_in,
  input  logic signed [39:0]      sum_in,
  output mlp_fe_pkg::act_meta_t   meta_out,
  output logic signed [15:0]      value_out
);

  mlp_fe_pkg::act_meta_t m1, m2, m3, m4;
  logic signed [40:0] r1;
  logic signed [15:0] s1_c, s1, s2;
  logic               c1;
  logic signed [16:0] neg_s;
  logic signed [15:0] recip_eff;
  logic signed [32:0] p2;
  logic               neg2;
  logic signed [33:0] r3;
  logic signed [20:0] t3;
  logic [20:0]        m3_mag;
  logic [12:0]        l0, l3_c, l3;
  logic signed [29:0] q4;
  logic signed [30:0] y5;
  logic signed [15:0] y5_sat;
  logic               c5;

  // Stage 1: round sum to Q4.12 and saturate
  always_comb begin
    r1   = (41'(sum_in) + 41'sd2048) >>> 12;
    c1   = 1'b0;
    s1_c = r1[15:0];
    if (r1 > 41'sd32767) begin
      s1_c = 16'sh7fff;
      c1 = 1'b1;
    end else if (r1 < -41'sd32768) begin
      s1_c = -16'sh8000;
      c1 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m1 <= '0;
    else m1 <= '{valid: meta_in.valid, clip: meta_in.clip | c1, idx: meta_in.idx};
    s1 <= s1_c;
  end

  // Stage 2: negative sums scaled by the reciprocal slope
  assign neg_s     = -17'(s1);
  assign recip_eff = (cfg.recip == 16'sd0) ? 16'sd4096 : cfg.recip;

  always_ff @(posedge clk) begin
    if (rst) m2 <= '0;
    else m2 <= m1;
    p2   <= 33'(neg_s) * 33'(recip_eff);
    neg2 <= s1[15];
    s2   <= s1;
  end

  // Stage 3: logistic lookup of the magnitude
  always_comb begin
    r3     = (34'(p2) + 34'sd2048) >>> 12;
    t3     = neg2 ? r3[20:0] : 21'(s2);
    m3_mag = t3[20] ? 21'(-t3) : 21'(t3);
    l0     = (|m3_mag[20:15]) ? 13'd4096 : mlp_fe_pkg::LOGI_TAB[m3_mag[14:7]];
    l3_c   = t3[20] ? (13'd4096 - l0) : l0;
  end

  always_ff @(posedge clk) begin
    if (rst) m3 <= '0;
    else m3 <= m2;
    l3 <= l3_c;
  end

  // Stage 4: gain
  always_ff @(posedge clk) begin
    if (rst) m4 <= '0;
    else m4 <= m3;
    q4 <= 30'(cfg.gain) * 30'($signed({1'b0, l3}));
  end

  // Stage 5: round, offset, saturate
  always_comb begin
    y5     = ((31'(q4) + 31'sd2048) >>> 12) + 31'(cfg.offset);
    c5     = 1'b0;
    y5_sat = y5[15:0];
    if (y5 > 31'sd32767) begin
      y5_sat = 16'sh7fff;
      c5 = 1'b1;
    end else if (y5 < -31'sd32768) begin
      y5_sat = -16'sh8000;
      c5 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) meta_out <= '0;
    else meta_out <= '{valid: m4.valid, clip: m4.clip | c5, idx: m4.idx};
    value_out <= y5_sat;
  end

endmodule

### design/mlp_forward_evaluator.sv
// Forward pass of a small fully connected net (2 to 4 layers, one output node).
// Weight and input-value transactions are accepted only while idle. An input
// transaction with last set starts a pass in which, for each layer
// (w_src = width of the source layer), the w_src source values stream through a
// chain of 32 MAC cells, the chain drains, the 32 sums shift out of the chain
// into the activation pipeline and a flush empties it. The result register
// loads from the done state after the last layer, later if the previous result
// is still held. The chain length sets the drain and shift lengths.
// No input is taken during a pass; one result follows it.
// Depends on mlp_fe_pkg, mlp_fe_cell, mlp_fe_act and the defines header.
`include "mlp_forward_evaluator_defines.svh"

module mlp_forward_evaluator (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  mlp_fe_pkg::item_t   item_data,
  output logic                result_valid,
  input  logic                result_stall,
  output mlp_fe_pkg::result_t result_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_STREAM = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_SHIFT  = 3'd3;
  localparam logic [2:0] ST_FLUSH  = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  localparam int NC = mlp_fe_pkg::NCELL;

  function automatic logic [5:0] clamp_w(input logic [5:0] w);
    logic [5:0] r;
    r = w;
    if (w == 6'd0) r = 6'd1;
    else if (w > 6'(NC)) r = 6'(NC);
    return r;
  endfunction

  // Configuration registers
  logic [2:0]            layer_count;
  logic [5:0]            input_width, hidden_one_width, hidden_two_width;
  mlp_fe_pkg::act_cfg_t  act_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count      <= 3'd3;
      input_width      <= 6'd32;
      hidden_one_width <= 6'd32;
      hidden_two_width <= 6'd16;
      act_cfg.gain     <= 16'sd4096;
      act_cfg.recip    <= 16'sd4096;
      act_cfg.offset   <= 16'sd0;
    end else if (cfg_we) begin
      case (cfg_index)
        mlp_fe_pkg::REG_LAYER_COUNT: layer_count      <= cfg_data[2:0];
        mlp_fe_pkg::REG_INPUT_WIDTH: input_width      <= cfg_data[5:0];
        mlp_fe_pkg::REG_HIDDEN_ONE:  hidden_one_width <= cfg_data[5:0];
        mlp_fe_pkg::REG_HIDDEN_TWO:  hidden_two_width <= cfg_data[5:0];
        mlp_fe_pkg::REG_GAIN_A:      act_cfg.gain     <= cfg_data;
        mlp_fe_pkg::REG_NEG_RECIP:   act_cfg.recip    <= cfg_data;
        mlp_fe_pkg::REG_OFFSET_C:    act_cfg.offset   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control registers
  logic [2:0] state;
  logic [1:0] layer;
  logic [5:0] cnt;
  logic       clip_seen;
  logic signed [15:0] score;

  // Layer geometry
  logic [2:0] nl;
  logic [5:0] w_src, w_dst;
  logic       is_out;

  always_comb begin
    nl = layer_count;
    if (layer_count < 3'd2) nl = 3'd2;
    else if (layer_count > 3'd4) nl = 3'd4;
    is_out = ({1'b0, layer} == nl - 3'd1);
    case (layer)
      2'd2:    w_src = clamp_w(hidden_one_width);
      2'd3:    w_src = clamp_w(hidden_two_width);
      default: w_src = clamp_w(input_width);
    endcase
    if (is_out) w_dst = 6'd1;
    else begin
      case (layer)
        2'd2:    w_dst = clamp_w(hidden_two_width);
        default: w_dst = clamp_w(hidden_one_width);
      endcase
    end
  end

  logic item_acc;
  assign item_stall = (state != ST_IDLE);
  assign item_acc   = item_valid && !item_stall;

  // Node value store and its sequential read
  logic signed [15:0] nv_mem [4 * NC];
  logic signed [15:0] rd_data;
  logic               rd_v;
  logic [4:0]         rd_k;
  logic [1:0]         src_layer;

  mlp_fe_pkg::act_meta_t act_in_meta, act_out_meta;
  logic signed [15:0]    act_out_value;

  assign src_layer = layer - 2'd1;

  always_ff @(posedge clk) begin
    if (item_acc && item_data.func == mlp_fe_pkg::FUNC_INPUT)
      nv_mem[{2'b00, item_data.input_position}] <= item_data.value;
    else if (act_out_meta.valid)
      nv_mem[{layer, act_out_meta.idx}] <= act_out_value;
  end

  always_ff @(posedge clk) begin
    rd_data <= nv_mem[{src_layer, cnt[4:0]}];
    rd_k    <= cnt[4:0];
    if (rst) rd_v <= 1'b0;
    else rd_v <= (state == ST_STREAM);
  end

  // Cell chain
  mlp_fe_pkg::tok_t   tok_chain [NC + 1];
  logic signed [39:0] acc_chain [NC + 1];
  logic               clip_chain [NC + 1];
  logic [NC-1:0]      wt_we;
  logic               shift;

  assign tok_chain[0]  = '{valid: rd_v, first: (rd_k == 5'd0), k: rd_k, value: rd_data};
  assign acc_chain[0]  = '0;
  assign clip_chain[0] = 1'b0;
  assign shift         = (state == ST_SHIFT);

  genvar j;
  generate
    for (j = 0; j < NC; j++) begin : g_cell
      assign wt_we[j] = item_acc && item_data.func == mlp_fe_pkg::FUNC_WEIGHT &&
                        item_data.weight_gap != mlp_fe_pkg::GAP_NONE &&
                        item_data.to_node == 5'(j);
      mlp_fe_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .wt_we   (wt_we[j]),
        .wt_addr ({item_data.weight_gap, item_data.from_node}),
        .wt_data (item_data.value),
        .gap     (src_layer),
        .tok_in  (tok_chain[j]),
        .tok_out (tok_chain[j+1]),
        .shift   (shift),
        .acc_in  (acc_chain[j]),
        .clip_in (clip_chain[j]),
        .acc     (acc_chain[j+1]),
        .clip    (clip_chain[j+1])
      );
    end
  endgenerate

  // Sums leave the chain end, highest node first
  logic [4:0] out_idx;
  assign out_idx = 5'(NC - 1) - cnt[4:0];
  assign act_in_meta = '{valid: shift && ({1'b0, out_idx} < w_dst),
                         clip: clip_chain[NC], idx: out_idx};

  mlp_fe_act u_act (
    .clk       (clk),
    .rst       (rst),
    .cfg       (act_cfg),
    .meta_in   (act_in_meta),
    .sum_in    (acc_chain[NC]),
    .meta_out  (act_out_meta),
    .value_out (act_out_value)
  );

  // Pass sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      layer     <= 2'd1;
      cnt       <= '0;
      clip_seen <= 1'b0;
    end else begin
      if (act_out_meta.valid) clip_seen <= clip_seen | act_out_meta.clip;
      case (state)
        ST_IDLE: begin
          if (item_acc && item_data.func == mlp_fe_pkg::FUNC_INPUT && item_data.last) begin
            clip_seen <= 1'b0;
            layer     <= 2'd1;
            cnt       <= '0;
            state     <= ST_STREAM;
          end
        end
        ST_STREAM: begin
          if (cnt == w_src - 6'd1) begin
            cnt   <= '0;
            state <= ST_DRAIN;
          end else cnt <= cnt + 6'd1;
        end
        ST_DRAIN: begin
          if (cnt == 6'(mlp_fe_pkg::DRAIN_LEN - 1)) begin
            cnt   <= '0;
            state <= ST_SHIFT;
          end else cnt <= cnt + 6'd1;
        end
        ST_SHIFT: begin
          if (cnt == 6'(NC - 1)) begin
            cnt   <= '0;
            state <= ST_FLUSH;
          end else cnt <= cnt + 6'd1;
        end
        ST_FLUSH: begin
          if (cnt == 6'(mlp_fe_pkg::FLUSH_LEN - 1)) begin
            cnt <= '0;
            if (is_out) state <= ST_DONE;
            else begin
              layer <= layer + 2'd1;
              state <= ST_STREAM;
            end
          end else cnt <= cnt + 6'd1;
        end
        ST_DONE: begin
          if (!result_valid || !result_stall) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output node value
  always_ff @(posedge clk) begin
    if (act_out_meta.valid && is_out) score <= act_out_value;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (state == ST_DONE && (!result_valid || !result_stall)) begin
      result_valid <= 1'b1;
      result_data  <= '{score: score, saturated: clip_seen};
    end else if (!result_stall) result_valid <= 1'b0;
  end

  `MLP_FE_ASSERT_IMP(a_act_busy, act_out_meta.valid, state != ST_IDLE, "activation write while idle")
  `MLP_FE_ASSERT_IMP(a_shift_no_tok, state == ST_SHIFT, !tok_chain[0].valid, "token during shift")
  `MLP_FE_ASSERT_NXT(a_res_src, !result_valid && state != ST_DONE, !result_valid, "result without pass")

endmodule
